[hw/rtl/cch_pkg.sv]
package cch_pkg;

	typedef struct packed {
		logic              operation;
		logic signed [15:0] mag_x;
		logic signed [15:0] mag_y;
	} req_t;

	typedef struct packed {
		logic [15:0] heading;
		logic        uncalibrated;
	} rsp_t;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	localparam int ATAN_ENTRIES = 24;
	localparam logic signed [35:0] PI_Q30     = 36'sd3373259426;
	localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;

	localparam logic [3:0] ADDR_DECL = 4'd0;

	function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
		logic signed [35:0] r;
		begin
			case (i)
				5'd0:  r = 36'sh03243F6A8;
				5'd1:  r = 36'sh01DAC6705;
				5'd2:  r = 36'sh00FADBAFC;
				5'd3:  r = 36'sh007F56EA6;
				5'd4:  r = 36'sh003FEAB76;
				5'd5:  r = 36'sh001FFD55B;
				5'd6:  r = 36'sh000FFFAAA;
				5'd7:  r = 36'sh0007FFF55;
				5'd8:  r = 36'sh0003FFFEA;
				5'd9:  r = 36'sh0001FFFFD;
				5'd10: r = 36'sh0000FFFFF;
				5'd11: r = 36'sh00007FFFF;
				5'd12: r = 36'sh00003FFFF;
				5'd13: r = 36'sh00001FFFF;
				5'd14: r = 36'sh00000FFFF;
				5'd15: r = 36'sh000007FFF;
				5'd16: r = 36'sh000003FFF;
				5'd17: r = 36'sh000001FFF;
				5'd18: r = 36'sh000000FFF;
				5'd19: r = 36'sh0000007FF;
				5'd20: r = 36'sh0000003FF;
				5'd21: r = 36'sh0000001FF;
				5'd22: r = 36'sh0000000FF;
				5'd23: r = 36'sh00000007F;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

[hw/rtl/calibrated_compass_heading_top.sv]
// Channel   Direction  Payload          Handshake
// req       in         cch_pkg::req_t   req_valid / req_stall
// rsp       out        cch_pkg::rsp_t   rsp_valid / rsp_stall
// apb       in         declination      psel/penable/pwrite, pready=1
//
// A heading sample runs the divider for X, then for Y, then the CORDIC;
// the X and Y divisions share one serial divider. A zero vector skips the
// CORDIC. An uncalibrated sample skips the divider and the CORDIC, and a
// clear only resets the calibration window and returns no response.
// Reset clears calibration window and declination. A held result in the
// output register blocks the next request until rsp is taken.
module calibrated_compass_heading_top #(
	parameter int ANGLE_FRAC_BITS = 13,
	parameter int CORDIC_STEPS    = 16,
	parameter int RATIO_FRAC_BITS = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  cch_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output cch_pkg::rsp_t rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [1:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	localparam int RW = RATIO_FRAC_BITS + 2;
	localparam int SH = 30 - ANGLE_FRAC_BITS;
	localparam logic signed [35:0] HALF = 36'sd1 <<< (SH - 1);
	localparam logic signed [35:0] TWO_PI_OUT = (cch_pkg::TWO_PI_Q30 + HALF) >>> SH;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHK  = 3'd1;
	localparam logic [2:0] ST_DIVX = 3'd2;
	localparam logic [2:0] ST_DIVY = 3'd3;
	localparam logic [2:0] ST_CORD = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0] state_q;
	logic signed [15:0] decl_q;
	logic signed [15:0] xl_q, xh_q, yl_q, yh_q, x_q, y_q;
	logic signed [RW-1:0] rx_q, ry_q;
	logic signed [35:0] ang_q;
	cch_pkg::rsp_t rsp_q;
	logic rsp_valid_q;

	logic accept, cfg_wr;
	logic signed [15:0] v, lo, hi;
	logic signed [17:0] num, den;
	logic num_neg;
	logic [17:0] anum;
	logic div_start, div_done, cord_start, cord_done;
	logic [RATIO_FRAC_BITS:0] quo;
	logic signed [RW-1:0] ratio;
	logic signed [35:0] angle, h;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && (paddr == cch_pkg::ADDR_DECL[1:0]);
	assign prdata    = (paddr == cch_pkg::ADDR_DECL[1:0]) ? 32'(decl_q) : '0;
	assign req_stall = (state_q != ST_IDLE) || rsp_valid_q;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Select the axis for the shared divider.
	always_comb begin
		if (state_q == ST_DIVY) begin
			v = y_q; lo = yl_q; hi = yh_q;
		end else begin
			v = x_q; lo = xl_q; hi = xh_q;
		end
		num     = (18'(v) <<< 1) - (18'(hi) + 18'(lo));
		den     = (18'(hi) - 18'(lo)) <<< 1;
		num_neg = num[17];
		anum    = num_neg ? 18'(-num) : 18'(num);
		ratio   = num_neg ? -RW'(quo) : RW'(quo);
	end

	cch_div #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(anum), .den(den), .done(div_done), .quo(quo)
	);

	cch_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_cord (
		.clk(clk), .arst_n(arst_n), .start(cord_start),
		.x_in(rx_q), .y_in(ry_q), .done(cord_done), .angle(angle)
	);

	logic div_go_q;
	logic cord_go_q;
	assign div_start  = div_go_q;
	assign cord_start = cord_go_q;

	// Round to output units and add declination.
	assign h = ((ang_q + HALF) >>> SH) + 36'(decl_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			decl_q      <= '0;
			xl_q <= '0; xh_q <= '0; yl_q <= '0; yh_q <= '0;
			div_go_q    <= 1'b0;
			cord_go_q   <= 1'b0;
		end else begin
			div_go_q  <= 1'b0;
			cord_go_q <= 1'b0;
			if (cfg_wr) decl_q <= pwdata[15:0];
			if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.operation == cch_pkg::OP_CLEAR) begin
							xl_q <= '0; xh_q <= '0; yl_q <= '0; yh_q <= '0;
						end else begin
							// Widen the window: low wins over high.
							if (req.mag_x < xl_q) xl_q <= req.mag_x;
							else if (req.mag_x > xh_q) xh_q <= req.mag_x;
							if (req.mag_y < yl_q) yl_q <= req.mag_y;
							else if (req.mag_y > yh_q) yh_q <= req.mag_y;
							state_q <= ST_CHK;
						end
					end
				end
				ST_CHK: begin
					if (xl_q == xh_q || yl_q == yh_q) begin
						rsp_q.heading      <= '0;
						rsp_q.uncalibrated <= 1'b1;
						rsp_valid_q        <= 1'b1;
						state_q            <= ST_IDLE;
					end else begin
						div_go_q <= 1'b1;
						state_q  <= ST_DIVX;
					end
				end
				ST_DIVX: begin
					if (div_done) begin
						rx_q     <= ratio;
						div_go_q <= 1'b1;
						state_q  <= ST_DIVY;
					end
				end
				ST_DIVY: begin
					if (div_done) begin
						ry_q <= ratio;
						if ((rx_q == 0) && (ratio == 0)) begin
							ang_q   <= '0;
							state_q <= ST_FIN;
						end else begin
							// Start the CORDIC once both ratios are registered.
							cord_go_q <= 1'b1;
							state_q   <= ST_CORD;
						end
					end
				end
				ST_CORD: begin
					if (cord_done) begin
						ang_q   <= angle;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// Wrap once into 0..2pi.
					if (h < 0) rsp_q.heading <= 16'(h + TWO_PI_OUT);
					else if (h > TWO_PI_OUT) rsp_q.heading <= 16'(h - TWO_PI_OUT);
					else rsp_q.heading <= 16'(h);
					rsp_q.uncalibrated <= 1'b0;
					rsp_valid_q        <= 1'b1;
					state_q            <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture sample values for the divider.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= req.mag_x;
			y_q <= req.mag_y;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> req_stall) else $error("request taken while busy");
	a_uncal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.uncalibrated) |-> (rsp.heading == 16'd0))
		else $error("uncalibrated heading not zero");
	a_cord_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		cord_done |-> (state_q == ST_CORD)) else $error("stray cordic done");
`endif
endmodule

[hw/rtl/cch_div.sv]
// Restoring divider: quotient = floor((num << FRAC) / den), one bit per cycle.
module cch_div #(
	parameter int RATIO_FRAC_BITS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [17:0] num,
	input  logic [17:0] den,
	output logic        done,
	output logic [RATIO_FRAC_BITS:0] quo
);
	localparam int QW = RATIO_FRAC_BITS + 1;
	localparam int CW = $clog2(QW + 1);

	logic [QW-1:0] quo_q;
	logic [18:0]   rem_q;
	logic [17:0]   num_q;
	logic [17:0]   den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [18:0]   trial;
	logic [19:0]   diff;
	logic [CW-1:0] bitpos;

	// Quotient bits come out MSB first; the numerator's low bit shifts in, then zeros.
	assign bitpos = CW'(QW - 1) - cnt_q;
	always_comb begin
		trial = {rem_q[17:0], (bitpos >= CW'(RATIO_FRAC_BITS)) ? num_q[17] : 1'b0};
		diff  = {1'b0, trial} - {2'b0, den_q};
	end

	// Iterate the shift-subtract step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// Preload num's high bits into the remainder so that the first step shifts in num's low bit.
			rem_q <= {1'b0, 18'(num >> 1)};
			num_q <= {num[0], 17'b0};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (!diff[19]) begin
				rem_q <= diff[18:0];
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
			num_q <= {num_q[16:0], 1'b0};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

[hw/rtl/cch_cordic.sv]
// Vectoring CORDIC: one micro-rotation per cycle on a shared add/shift datapath.
module cch_cordic #(
	parameter int CORDIC_STEPS    = 16,
	parameter int RATIO_FRAC_BITS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic signed [RATIO_FRAC_BITS+1:0] x_in,
	input  logic signed [RATIO_FRAC_BITS+1:0] y_in,
	output logic        done,
	output logic signed [35:0] angle
);
	localparam int VW = RATIO_FRAC_BITS + 4;
	localparam int NS = (CORDIC_STEPS < cch_pkg::ATAN_ENTRIES) ? CORDIC_STEPS
		: cch_pkg::ATAN_ENTRIES;

	logic signed [VW-1:0] x_q, y_q, dx, dy;
	logic signed [35:0]   z_q;
	logic [4:0]           step_q;
	logic                 busy_q, done_q;

	assign dx = x_q >>> step_q;
	assign dy = y_q >>> step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == 5'(NS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Fold the left half plane, then rotate toward y = 0.
	always_ff @(posedge clk) begin
		if (start) begin
			if (x_in < 0) begin
				x_q <= -VW'(x_in);
				y_q <= -VW'(y_in);
				z_q <= (y_in >= 0) ? cch_pkg::PI_Q30 : -cch_pkg::PI_Q30;
			end else begin
				x_q <= VW'(x_in);
				y_q <= VW'(y_in);
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + dy;
				y_q <= y_q - dx;
				z_q <= z_q + cch_pkg::atan_q30(step_q);
			end else if (y_q < 0) begin
				x_q <= x_q - dy;
				y_q <= y_q + dx;
				z_q <= z_q - cch_pkg::atan_q30(step_q);
			end
		end
	end

	assign done  = done_q;
	assign angle = z_q;
endmodule
